// ===== hdl/qts_pkg.sv =====
// shared types and constants for the two-stack queue
`default_nettype none
package qts_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int DATA_W          = 32;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_MOVE
	} state_t;

	typedef struct packed {
		logic                     mode;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] item_out;
	} rsp_t;

endpackage
`default_nettype wire

// ===== hdl/qts_stack_ram.sv =====
// stack storage: one write port, one registered read port
`default_nettype none
module qts_stack_ram #(
	parameter int DEPTH = qts_pkg::STACK_DEPTH_DEF,
	parameter int WIDTH = qts_pkg::DATA_W,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/queue_from_two_stacks.sv =====
// fifo queue built from an inbound and an outbound stack memory
// enqueue, overflow and underflow: result register loaded by the transfer, valid in the next cycle
// dequeue with outbound stack filled: item passes the outbound ram read register, then the result register
// dequeue with outbound stack empty: inbound items walk to the outbound stack, one item moved per cycle
// a new request is taken only in idle and only while the result slot is free or being read
// reset clears both counts and the handshake state; stack memories are not cleared
`default_nettype none
module queue_from_two_stacks #(
	parameter int STACK_DEPTH = qts_pkg::STACK_DEPTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         req_valid,
	output logic              req_ready,
	input  wire qts_pkg::req_t req,
	output logic              rsp_valid,
	input  wire logic         rsp_ready,
	output qts_pkg::rsp_t     rsp
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int DW = qts_pkg::DATA_W;

	qts_pkg::state_t state_q, state_d;

	logic [CW-1:0] in_cnt_q, in_cnt_d, out_cnt_q, out_cnt_d;
	logic [CW-1:0] in_cnt_dec, out_cnt_dec;
	logic          mv_s1, mv_d;
	logic          out_valid_q;
	qts_pkg::rsp_t rsp_q, rsp_d;
	logic          rsp_load;

	logic          in_we, out_we;
	logic [AW-1:0] in_waddr, in_raddr, out_waddr, out_raddr;
	logic [DW-1:0] in_rdata, out_rdata;
	logic          accept;

	assign in_cnt_dec  = in_cnt_q - CW'(1);
	assign out_cnt_dec = out_cnt_q - CW'(1);

	assign req_ready = (state_q == qts_pkg::S_IDLE) && (!out_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	qts_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DW)) u_inbound (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_waddr),
		.wdata (req.value),
		.raddr (in_raddr),
		.rdata (in_rdata)
	);

	qts_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DW)) u_outbound (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_waddr),
		.wdata (in_rdata),
		.raddr (out_raddr),
		.rdata (out_rdata)
	);

	always_comb begin
		state_d   = state_q;
		in_cnt_d  = in_cnt_q;
		out_cnt_d = out_cnt_q;
		mv_d      = 1'b0;
		in_we     = 1'b0;
		out_we    = 1'b0;
		in_waddr  = in_cnt_q[AW-1:0];
		in_raddr  = in_cnt_dec[AW-1:0];
		out_waddr = out_cnt_q[AW-1:0];
		out_raddr = out_cnt_dec[AW-1:0];
		rsp_load  = 1'b0;
		rsp_d.status   = qts_pkg::ST_OK;
		rsp_d.item_out = '0;
		case (state_q)
			qts_pkg::S_IDLE: begin
				if (accept) begin
					if (req.mode == qts_pkg::MODE_ENQ) begin
						rsp_load = 1'b1;
						if (in_cnt_q == CW'(STACK_DEPTH)) begin
							rsp_d.status = qts_pkg::ST_OVERFLOW;
						end else begin
							in_we    = 1'b1;
							in_cnt_d = in_cnt_q + CW'(1);
						end
					end else if (out_cnt_q != '0) begin
						out_cnt_d = out_cnt_dec;
						state_d   = qts_pkg::S_POP;
					end else if (in_cnt_q != '0) begin
						in_cnt_d = in_cnt_dec;
						mv_d     = 1'b1;
						state_d  = qts_pkg::S_MOVE;
					end else begin
						rsp_load     = 1'b1;
						rsp_d.status = qts_pkg::ST_UNDERFLOW;
					end
				end
			end
			qts_pkg::S_POP: begin
				rsp_load       = 1'b1;
				rsp_d.item_out = $signed(out_rdata);
				state_d        = qts_pkg::S_IDLE;
			end
			qts_pkg::S_MOVE: begin
				if (in_cnt_q != '0) begin
					in_cnt_d = in_cnt_dec;
					mv_d     = 1'b1;
				end
				if (mv_s1) begin
					if (in_cnt_q == '0) begin
						rsp_load       = 1'b1;
						rsp_d.item_out = $signed(in_rdata);
						state_d        = qts_pkg::S_IDLE;
					end else begin
						out_we    = 1'b1;
						out_cnt_d = out_cnt_q + CW'(1);
					end
				end
			end
			default: begin
				state_d = qts_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			mv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			in_cnt_q  <= in_cnt_d;
			out_cnt_q <= out_cnt_d;
			mv_s1     <= mv_d;
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/qts_checker.sv =====
// port-level checks for the two-stack queue, bound to the top level
`default_nettype none
module qts_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire qts_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire qts_pkg::rsp_t rsp
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// error results carry a zero item
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != qts_pkg::ST_OK) |-> rsp.item_out == '0)
		else $error("error result with nonzero item");

	// no new request taken while the result slot is blocked
	a_no_accept_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result slot full");

	// an overflow only answers an enqueue, so it never follows a dequeue directly
	a_ovf_enq: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.mode == qts_pkg::MODE_DEQ) |=>
		!(rsp_valid && (rsp.status == qts_pkg::ST_OVERFLOW) && $rose(rsp_valid)))
		else $error("overflow reported for a dequeue");

endmodule

bind queue_from_two_stacks qts_checker u_qts_checker (.*);
`default_nettype wire

// ===== bench/queue_from_two_stacks_tb.sv =====
// self-checking testbench for the two-stack queue: directed edge cases, then random traffic
`timescale 1ns / 1ps
module queue_from_two_stacks_tb;

	class two_stack_scoreboard_t;
		logic [qts_pkg::DATA_W-1:0] inbound_stack [qts_pkg::STACK_DEPTH_DEF];
		logic [qts_pkg::DATA_W-1:0] outbound_stack [qts_pkg::STACK_DEPTH_DEF];
		int inbound_count;
		int outbound_count;
		qts_pkg::rsp_t pending_rsp [$];
		int errors;
		int n_enq;
		int n_deq;
		int n_overflow;
		int n_underflow;
		int n_moves;

		function new();
			inbound_count = 0;
			outbound_count = 0;
			errors = 0;
			n_enq = 0;
			n_deq = 0;
			n_overflow = 0;
			n_underflow = 0;
			n_moves = 0;
		endfunction

		function void note_request(qts_pkg::req_t r);
			qts_pkg::rsp_t exp_rsp;
			exp_rsp.status = qts_pkg::ST_OK;
			exp_rsp.item_out = '0;
			if (r.mode == qts_pkg::MODE_ENQ) begin
				n_enq++;
				if (inbound_count >= qts_pkg::STACK_DEPTH_DEF) begin
					exp_rsp.status = qts_pkg::ST_OVERFLOW;
					n_overflow++;
				end else begin
					inbound_stack[inbound_count] = r.value;
					inbound_count++;
				end
			end else begin
				n_deq++;
				if (inbound_count == 0 && outbound_count == 0) begin
					exp_rsp.status = qts_pkg::ST_UNDERFLOW;
					n_underflow++;
				end else begin
					// refill reverses the inbound order so the oldest item is on top
					if (outbound_count == 0) begin
						n_moves++;
						while (inbound_count > 0 &&
							outbound_count < qts_pkg::STACK_DEPTH_DEF) begin
							inbound_count--;
							outbound_stack[outbound_count] = inbound_stack[inbound_count];
							outbound_count++;
						end
					end
					outbound_count--;
					exp_rsp.item_out = outbound_stack[outbound_count];
				end
			end
			pending_rsp.push_back(exp_rsp);
		endfunction

		function void check_response(qts_pkg::rsp_t got);
			qts_pkg::rsp_t exp_rsp;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d item %h",
					$time, got.status, got.item_out);
				errors++;
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (got.status !== exp_rsp.status || got.item_out !== exp_rsp.item_out) begin
					$display("%0t: expected status %0d item %h, got status %0d item %h",
						$time, exp_rsp.status, exp_rsp.item_out, got.status, got.item_out);
					errors++;
				end
			end
		endfunction

		function int pending();
			return pending_rsp.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	qts_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	qts_pkg::rsp_t rsp;

	two_stack_scoreboard_t board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	queue_from_two_stacks dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// receiver: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				board.check_response(rsp);
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [qts_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input qts_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		board.note_request(r);
	endtask

	task automatic enqueue(input logic [qts_pkg::DATA_W-1:0] v);
		qts_pkg::req_t r;
		r.mode = qts_pkg::MODE_ENQ;
		r.value = v;
		send_item(r);
	endtask

	task automatic dequeue();
		qts_pkg::req_t r;
		r.mode = qts_pkg::MODE_DEQ;
		r.value = pick_value();
		send_item(r);
	endtask

	// bursts with a changing enqueue bias so both full and empty are reached often
	task automatic run_random(input int count);
		int left;
		int seg;
		int enq_pct;
		qts_pkg::req_t r;
		left = count;
		while (left > 0) begin
			seg = $urandom_range(60, 20);
			case ($urandom_range(2))
				0: enq_pct = 25;
				1: enq_pct = 50;
				default: enq_pct = 75;
			endcase
			for (int k = 0; k < seg && left > 0; k++) begin
				r.mode = ($urandom_range(99) < enq_pct) ? qts_pkg::MODE_ENQ : qts_pkg::MODE_DEQ;
				r.value = pick_value();
				send_item(r);
				left--;
			end
		end
	endtask

	initial begin
		#5ms;
		$display("%0t: timeout", $time);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dequeue();
		enqueue(32'h7FFF_FFFF);
		enqueue(32'h8000_0000);
		enqueue(32'h0000_0000);
		enqueue(32'hFFFF_FFFF);
		for (int i = 0; i < qts_pkg::STACK_DEPTH_DEF - 4; i++) begin
			enqueue($urandom);
		end
		enqueue(32'h5555_5555);
		dequeue();
		enqueue(32'hAAAA_AAAA);
		dequeue();

		// long receiver hold-off while the sender keeps pushing
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		run_random(380);

		send_idle_pct = 83;
		recv_stall_pct = 0;
		run_random(380);

		send_idle_pct = 0;
		recv_stall_pct = 83;
		run_random(380);

		send_idle_pct = 6;
		recv_stall_pct = 6;
		run_random(380);

		req_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, board.pending());
			board.errors++;
		end

		$display("covered %0d enqueues (%0d refused on a full inbound stack) and %0d dequeues",
			board.n_enq, board.n_overflow, board.n_deq);
		$display("%0d dequeues on an empty queue, %0d refills of the outbound stack, %0d errors",
			board.n_underflow, board.n_moves, board.errors);
		if (board.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
